// ===== rtl/shared_interrupt_controller_macros.svh =====
// Assertion macros shared by the checker of the interrupt controller.
`ifndef SHARED_INTERRUPT_CONTROLLER_MACROS_SVH
`define SHARED_INTERRUPT_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define SIC_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define SIC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define SIC_ASSERT_ALWAYS_NEXT(lbl, clk, a, c, msg) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/sic_pkg.sv =====
package sic_pkg;

    localparam int PIN_COUNT = 6;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LINE  = 2'd2;

    localparam logic [13:0] ADDR_CONFIG   = 14'h0000;
    localparam logic [13:0] ADDR_POLARITY = 14'h0100;
    localparam logic [13:0] ADDR_TRIGGER  = 14'h0180;
    localparam logic [13:0] ADDR_DUAL     = 14'h0200;
    localparam logic [13:0] ADDR_WEDGE    = 14'h0280;
    localparam logic [13:0] ADDR_MASK_RST = 14'h0300;
    localparam logic [13:0] ADDR_MASK_SET = 14'h0380;
    localparam logic [13:0] ADDR_MASK     = 14'h0400;
    localparam logic [13:0] ADDR_PENDING  = 14'h0480;
    localparam logic [13:0] ADDR_PIN_MAP  = 14'h0500;
    localparam logic [13:0] ADDR_PIN_END  = 14'h0900;

    // Configuration register index: core count.
    localparam logic REG_CORE_COUNT = 1'b0;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_ctl_sts;

    // True when the address lies in the 32-byte register bank at base.
    function automatic logic f_bank(input logic [13:0] a, input logic [13:0] base);
        return a[13:5] == base[13:5];
    endfunction

    // Position of the lowest set bit; zero when none is set.
    function automatic logic [4:0] f_lowest(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/sic_ctrl.sv =====
module sic_ctrl import sic_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sic_dp.sv =====
module sic_dp import sic_pkg::*; #(
    parameter int SOURCE_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_sts    o_sts,
    input  logic [1:0]  i_command,
    input  logic [13:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_line_index,
    input  logic        i_line_level,
    input  logic [5:0]  i_core_count,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_read_data,
    output logic [7:0]  o_first_pending,
    output logic        o_any_pending,
    output logic [5:0]  o_cpu_pins
);

    localparam int WC = (SOURCE_COUNT + 31) / 32;
    localparam int WB = (WC > 1) ? $clog2(WC) : 1;
    localparam int SB = $clog2(SOURCE_COUNT);

    logic [31:0] r_pol  [WC];
    logic [31:0] r_trg  [WC];
    logic [31:0] r_dual [WC];
    logic [31:0] r_en   [WC];
    logic [31:0] r_lat  [WC];
    logic [31:0] r_lin  [WC];
    logic [31:0] r_pinm [PIN_COUNT][WC];
    logic [31:0] c_vmask [WC];

    logic [3:0]  r_pm_mem [SOURCE_COUNT];
    logic [SOURCE_COUNT-1:0] r_pm_vld;
    logic [3:0]  r_pm_q;
    logic        r_pm_qv;
    logic        r_is_pm;

    logic [1:0]  r_cmd;
    logic [13:0] r_addr;
    logic [31:0] r_data;
    logic [7:0]  r_lidx;
    logic        r_lvl;

    logic [WB-1:0] r_cnt;
    logic [31:0]   r_rd;
    logic          r_any;
    logic [7:0]    r_first;
    logic [5:0]    r_pins;

    logic [2:0]    x_widx;
    logic [2:0]    e_widx;
    logic          w_ok;
    logic [WB-1:0] ri;
    logic [31:0]   pol_w, trg_w, dual_w, en_w, lat_w, lin_w, vm_w, pend_w, act_w;
    logic [5:0]    pm_hit;
    logic          is_wr, h_pol, h_trg, h_dual, h_mrst, h_mset, h_mask, h_pend;
    logic          wg, l_ok, edge_hit, pm_ok, pw;
    logic [4:0]    bsel;
    logic [7:0]    pm_i8;
    logic [2:0]    pm_w3;
    logic [31:0]   rd_v;

    for (genvar g = 0; g < WC; g++) begin : g_vmask
        localparam int REM = SOURCE_COUNT - g * 32;
        assign c_vmask[g] = (REM >= 32) ? 32'hffff_ffff : ((32'd1 << REM) - 32'd1);
    end

    // One word index per cycle: the command's word while executing, else the scan word.
    always_comb begin
        if (r_cmd == CMD_LINE) begin
            x_widx = r_lidx[7:5];
        end else if (r_cmd == CMD_WRITE && r_addr == ADDR_WEDGE) begin
            x_widx = r_data[7:5];
        end else begin
            x_widx = r_addr[4:2];
        end
    end

    assign e_widx = i_cmd.exec ? x_widx : 3'(r_cnt);
    assign w_ok   = {1'b0, e_widx} < 4'(WC);
    assign ri     = e_widx[WB-1:0];

    assign pol_w  = w_ok ? r_pol[ri]   : '0;
    assign trg_w  = w_ok ? r_trg[ri]   : '0;
    assign dual_w = w_ok ? r_dual[ri]  : '0;
    assign en_w   = w_ok ? r_en[ri]    : '0;
    assign lat_w  = w_ok ? r_lat[ri]   : '0;
    assign lin_w  = w_ok ? r_lin[ri]   : '0;
    assign vm_w   = w_ok ? c_vmask[ri] : '0;
    assign pend_w = ((trg_w & lat_w) | (~trg_w & ~(lin_w ^ pol_w))) & vm_w;
    assign act_w  = pend_w & en_w;

    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
        assign pm_hit[p] = |(act_w & r_pinm[p][ri]);
    end

    assign is_wr  = (r_cmd == CMD_WRITE);
    assign h_pol  = f_bank(r_addr, ADDR_POLARITY) && w_ok;
    assign h_trg  = f_bank(r_addr, ADDR_TRIGGER)  && w_ok;
    assign h_dual = f_bank(r_addr, ADDR_DUAL)     && w_ok;
    assign h_mrst = f_bank(r_addr, ADDR_MASK_RST) && w_ok;
    assign h_mset = f_bank(r_addr, ADDR_MASK_SET) && w_ok;
    assign h_mask = f_bank(r_addr, ADDR_MASK)     && w_ok;
    assign h_pend = f_bank(r_addr, ADDR_PENDING)  && w_ok;

    assign bsel = (r_cmd == CMD_LINE) ? r_lidx[4:0] : r_data[4:0];
    assign wg   = is_wr && (r_addr == ADDR_WEDGE) && ({1'b0, r_data[7:0]} < 9'(SOURCE_COUNT));
    assign l_ok = (r_cmd == CMD_LINE) && ({1'b0, r_lidx} < 9'(SOURCE_COUNT));
    assign edge_hit = (lin_w[bsel] != r_lvl) && trg_w[bsel] &&
                      (dual_w[bsel] || (r_lvl == pol_w[bsel]));

    assign pm_i8 = 8'(r_addr[13:2] - ADDR_PIN_MAP[13:2]);
    assign pm_w3 = pm_i8[7:5];
    assign pm_ok = (r_addr >= ADDR_PIN_MAP) && (r_addr < ADDR_PIN_END) &&
                   ({1'b0, pm_i8} < 9'(SOURCE_COUNT));
    assign pw    = i_cmd.exec && is_wr && pm_ok;

    always_comb begin
        if (r_addr == ADDR_CONFIG) begin
            rd_v = {8'd0, 8'(SOURCE_COUNT / 8 - 1), 10'd0, 6'(i_core_count - 6'd1)};
        end else if (h_pol) begin
            rd_v = pol_w;
        end else if (h_trg) begin
            rd_v = trg_w;
        end else if (h_dual) begin
            rd_v = dual_w;
        end else if (h_mask) begin
            rd_v = en_w;
        end else if (h_pend) begin
            rd_v = pend_w;
        end else begin
            rd_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WC; w++) begin
                r_pol[w]  <= '0;
                r_trg[w]  <= '0;
                r_dual[w] <= '0;
                r_en[w]   <= '0;
                r_lat[w]  <= '0;
                r_lin[w]  <= '0;
                for (int p = 0; p < PIN_COUNT; p++) begin
                    r_pinm[p][w] <= '0;
                end
            end
            r_pm_vld <= '0;
        end else if (i_cmd.exec) begin
            if (is_wr) begin
                if (h_pol)  r_pol[ri]  <= r_data & vm_w;
                if (h_trg)  r_trg[ri]  <= r_data & vm_w;
                if (h_dual) r_dual[ri] <= r_data & vm_w;
                if (h_mrst) r_en[ri]   <= en_w & ~r_data;
                if (h_mset) r_en[ri]   <= en_w | (r_data & vm_w);
                if (wg)     r_lat[ri][bsel] <= r_data[31];
            end
            if (l_ok) begin
                if (edge_hit) r_lat[ri][bsel] <= 1'b1;
                r_lin[ri][bsel] <= r_lvl;
            end
            if (pw) begin
                r_pm_vld[pm_i8[SB-1:0]] <= 1'b1;
                for (int p = 0; p < PIN_COUNT; p++) begin
                    r_pinm[p][pm_w3[WB-1:0]][pm_i8[4:0]] <=
                        r_data[31] && (r_data[2:0] == 3'(p));
                end
            end
        end
    end

    // Pin map store: one port, read and write during the execute cycle only.
    always_ff @(posedge i_clk) begin
        if (pw) begin
            r_pm_mem[pm_i8[SB-1:0]] <= {r_data[31], r_data[2:0]};
        end
        if (i_cmd.exec) begin
            r_pm_q  <= r_pm_mem[pm_i8[SB-1:0]];
            r_pm_qv <= r_pm_vld[pm_i8[SB-1:0]];
            r_is_pm <= (r_cmd == CMD_READ) && pm_ok;
            r_rd    <= (r_cmd == CMD_READ) ? rd_v : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_addr <= {i_address[13:2], 2'b00};
            r_data <= i_write_data;
            r_lidx <= i_line_index;
            r_lvl  <= i_line_level;
        end
        if (i_cmd.exec) begin
            r_cnt   <= '0;
            r_any   <= 1'b0;
            r_first <= '0;
            r_pins  <= '0;
        end else if (i_cmd.scan) begin
            if (!r_any && (|act_w)) begin
                r_first <= {3'(r_cnt), f_lowest(act_w)};
            end
            r_any  <= r_any | (|act_w);
            r_pins <= r_pins | pm_hit;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_sts.scan_last = (r_cnt == WB'(WC - 1));
    assign o_sts.out_free  = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_is_pm) begin
                o_read_data <= r_pm_qv ? {r_pm_q[3], 28'd0, r_pm_q[2:0]} : '0;
            end else begin
                o_read_data <= r_rd;
            end
            o_first_pending <= r_first;
            o_any_pending   <= r_any;
            o_cpu_pins      <= r_pins;
        end
    end

endmodule

// ===== rtl/shared_interrupt_controller.sv =====
// Shared register section of an interrupt controller. Each input transfer is a
// bus read, a bus write or a change of one source line, and it yields exactly
// one output transfer carrying the read data (zero unless a read), the lowest
// pending and unmasked source, a flag for any such source, and six CPU pin
// levels. An item passes from input transfer to an output ready for transfer
// through capture, then execution of the command against the register words
// and pin map store, then a scan that walks the pending, mask and per-pin
// words one 32-source word at a time, and then the output register load, which
// waits while a stalled result still fills the output register. A new input is
// taken when the scan has finished and its result is in the output register,
// even if that result still waits downstream. The core count lives in an APB
// register at byte address 0; it resets to 1.
module shared_interrupt_controller import sic_pkg::*; #(
    parameter int SOURCE_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [13:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_line_index,
    input  logic        i_line_level,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [7:0]  o_first_pending,
    output logic        o_any_pending,
    output logic [5:0]  o_cpu_pins,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_ctl_cmd   ctl_cmd;
    t_ctl_sts   ctl_sts;
    logic [5:0] r_core_count;

    // The APB port never inserts wait states.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CORE_COUNT) ? {26'd0, r_core_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count <= 6'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CORE_COUNT) begin
            r_core_count <= pwdata[5:0];
        end
    end

    // The controller sequences capture, execute, scan and output load.
    sic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // The datapath holds the register words, pin map store and output register.
    sic_dp #(
        .SOURCE_COUNT (SOURCE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_sts           (ctl_sts),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_line_index    (i_line_index),
        .i_line_level    (i_line_level),
        .i_core_count    (r_core_count),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_read_data     (o_read_data),
        .o_first_pending (o_first_pending),
        .o_any_pending   (o_any_pending),
        .o_cpu_pins      (o_cpu_pins)
    );

endmodule

// ===== rtl/sic_checker.sv =====
`include "shared_interrupt_controller_macros.svh"

module sic_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_data,
    input logic [7:0]  o_first_pending,
    input logic        o_any_pending,
    input logic [5:0]  o_cpu_pins
);

    // One item at a time: an accepted transfer blocks the input next cycle.
    `SIC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after transfer")

    // With nothing pending, no source number and no pin may be reported.
    `SIC_ASSERT_NOW(a_idle_result, i_clk, i_rst_n, o_out_valid && !o_any_pending, o_first_pending == 8'd0 && o_cpu_pins == 6'd0, "result reports a source with none pending")

    // A stalled result stays offered.
    `SIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_first_pending), "stalled result changed")

    // Reset leaves no result and an open input.
    `SIC_ASSERT_ALWAYS_NEXT(a_reset_state, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "bad state after reset")

endmodule

bind shared_interrupt_controller sic_assertions u_sic_assertions (.*);
